>>> design/vrws_pkg.sv
package vrws_pkg;

  // Geometry of the smoother.
  localparam int unsigned MaxTaps    = 7;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned FracBits   = 14;

  // Widest reach of the window to either side of the centre tap.
  localparam int unsigned Reach   = MaxTaps / 2;
  localparam int unsigned WinTaps = 2 * Reach + 1;

  localparam int unsigned TapCntBits   = $clog2(MaxTaps + 1);
  localparam int unsigned PosBits      = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
  localparam int unsigned TapCountBits = 3;
  localparam int unsigned CfgIdxBits   = $clog2(MaxTaps + 1);
  localparam int unsigned CfgDataBits  = WeightBits;

  // Configuration register indexes.
  localparam int unsigned RegTapCount   = 0;
  localparam int unsigned RegWeightBase = 1;

  // Reset values of the configuration registers.
  localparam int unsigned TapCountReset = 1;
  localparam int          Weight0Reset  = 16384;

  // Datapath widths.
  localparam int unsigned ProdBits   = SampleBits + WeightBits + 1;
  localparam int unsigned AccBits    = ProdBits + $clog2(MaxTaps + 1);
  localparam int unsigned MagAccBits = AccBits - 1;
  localparam int unsigned SumBits    = WeightBits + $clog2(MaxTaps + 1);
  localparam int unsigned MagSumBits = SumBits - 1;
  localparam int unsigned LoBits     = (MagAccBits + 1) / 2;
  localparam int unsigned HiBits     = MagAccBits - LoBits;
  localparam int unsigned NumBits    = MagAccBits + MagSumBits;
  localparam int unsigned DenBits    = MagSumBits + FracBits;
  localparam int unsigned QuoBits    = SampleBits + 1;
  localparam int unsigned DivCntBits = $clog2(QuoBits);

  // Job queue between the front and the back.
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);

  typedef logic [SampleBits-1:0]        sample_t;
  typedef logic signed [WeightBits-1:0] weight_t;
  typedef logic [TapCntBits-1:0]        tap_cnt_t;
  typedef logic [PosBits-1:0]           pos_t;

  typedef struct packed {
    sample_t pitch_in;
    logic    final_in;
  } in_word_t;

  typedef struct packed {
    sample_t pitch_out;
    logic    final_out;
  } out_word_t;

  // One frame to smooth: the frames around it ordered by distance (the centre at Reach,
  // older frames above it), which of them the window may use, and the end-of-sequence mark.
  typedef struct packed {
    sample_t [WinTaps-1:0] win;
    logic [WinTaps-1:0]    use_tap;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic avail;
    job_t job;
  } q_rd_t;

  typedef enum logic {
    FrIdle,
    FrScan
  } front_state_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkMac,
    BkMulLo,
    BkMulHi,
    BkCheck,
    BkDiv,
    BkRound,
    BkEmit
  } back_state_e;

  // A tap count of zero acts as one, and counts beyond the window act as the full window.
  function automatic tap_cnt_t taps_in_use(logic [TapCountBits-1:0] tc);
    tap_cnt_t n;
    if (tc == '0) begin
      n = tap_cnt_t'(1);
    end else if (tc > MaxTaps) begin
      n = tap_cnt_t'(MaxTaps);
    end else begin
      n = tap_cnt_t'(tc);
    end
    return n;
  endfunction

endpackage

>>> design/voiced_run_weighted_smoother_core.sv
// A frame's jobs pass from the front through the job queue to the arithmetic unit, and each
//   word then waits in the output register for as long as the output is stalled.
// The back works on one job at a time; its pace is set by the 17-step restoring divider and
//   the serial multiply-accumulate, and unvoiced and clamped results skip the divider.
// Reset: asynchronous, active low; it empties the history and the job queue and loads the
//   registers with a single tap of weight 1.0.
module voiced_run_weighted_smoother_core import vrws_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_word_t               in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_word_t              out_word_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // Configuration registers, read directly by both halves without any shadow copy. The user
  // must change them only while the block is idle; the block itself does not enforce it.
  logic [TapCountBits-1:0] tap_count_q;
  weight_t                 weight_q [MaxTaps];
  tap_cnt_t                taps;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TapCountBits'(TapCountReset);
      for (int i = 0; i < MaxTaps; i++) begin
        weight_q[i] <= (i == 0) ? WeightBits'(Weight0Reset) : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxBits'(RegTapCount)) begin
        tap_count_q <= cfg_data_i[TapCountBits-1:0];
      end
      for (int i = 0; i < MaxTaps; i++) begin
        if (cfg_idx_i == CfgIdxBits'(RegWeightBase + i)) begin
          weight_q[i] <= $signed(cfg_data_i[WeightBits-1:0]);
        end
      end
    end
  end

  // A zero tap count behaves as a single tap.
  assign taps = taps_in_use(tap_count_q);

  // The front keeps the frame history. On each accepted word it shifts the new frame in,
  // then scans the held frames oldest first and queues one job for every frame whose
  // lookahead is complete, or for all of them when the word closes the sequence. Each job
  // carries the neighbouring frames and a mask of the taps that the voiced run allows, so
  // the history may move on while the back is still busy.
  vrws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .taps_i     (taps),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr)
  );

  // A four-deep queue covers the largest burst that one word can release.
  vrws_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  // The back sums weight times frame one tap per cycle, scales the sum by the total weight
  // in two half-width multiplies, then divides by the used weight bit by bit with rounding
  // to nearest. Its output register lets it take the next job while a word waits.
  vrws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_rd_i      (q_rd),
    .pop_o       (q_pop),
    .taps_i      (taps),
    .weights_i   (weight_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> design/vrws_front.sv
module vrws_front import vrws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  tap_cnt_t taps_i,
  input  logic     q_full_i,
  output q_wr_t    q_wr_o
);

  localparam int unsigned WinLen = MaxTaps + Reach;
  localparam int unsigned Centre = MaxTaps - 1;

  front_state_e state_q, state_d;

  sample_t  hist_q [MaxTaps];
  sample_t  hist_shift [MaxTaps];
  sample_t  win_q [WinLen];
  tap_cnt_t pend_q;
  pos_t     pos_q, hi_q, lo_q;
  logic     fin_q;

  tap_cnt_t               half, look, pend_sat;
  logic [TapCntBits:0]    pend_inc;
  logic                   accept, emit_any, in_range, advance;
  logic [WinTaps-1:0]     use_tap;
  logic                   older_ok, newer_ok;

  always_comb begin
    half     = taps_i >> 1;
    look     = tap_cnt_t'(taps_i - half - 1'b1);
    pend_inc = {1'b0, pend_q} + 1'b1;
    if (pend_inc > MaxTaps) begin
      pend_sat = tap_cnt_t'(MaxTaps);
    end else begin
      pend_sat = pend_inc[TapCntBits-1:0];
    end
    emit_any = in_word_i.final_in || (pend_sat > look);
    hist_shift[0] = in_word_i.pitch_in;
    for (int i = 1; i < MaxTaps; i++) begin
      hist_shift[i] = hist_q[i-1];
    end
  end

  // Window usage: the run of voiced neighbours on each side, cut at the tap reach.
  always_comb begin
    use_tap        = '0;
    use_tap[Reach] = 1'b1;
    older_ok       = 1'b1;
    newer_ok       = 1'b1;
    for (int r = 1; r <= Reach; r++) begin
      older_ok = older_ok && (win_q[Centre+r] != '0) && (half >= tap_cnt_t'(r));
      newer_ok = newer_ok && (win_q[Centre-r] != '0) && (look >= tap_cnt_t'(r));
      use_tap[Reach+r] = older_ok;
      use_tap[Reach-r] = newer_ok;
    end
  end

  always_comb begin
    for (int j = 0; j < WinTaps; j++) begin
      q_wr_o.job.win[j] = win_q[Centre-Reach+j];
    end
    q_wr_o.job.use_tap = use_tap;
    q_wr_o.job.last    = fin_q && (pos_q == '0);
    state_d     = state_q;
    in_ready_o  = 1'b0;
    in_range    = pos_q <= hi_q;
    q_wr_o.push = 1'b0;
    advance     = 1'b0;
    accept      = 1'b0;
    unique case (state_q)
      FrIdle: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (in_valid_i && emit_any) begin
          state_d = FrScan;
        end
      end
      FrScan: begin
        q_wr_o.push = in_range && !q_full_i;
        advance     = !in_range || q_wr_o.push;
        if (q_wr_o.push && (pos_q == lo_q)) begin
          state_d = FrIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      pend_q  <= '0;
      pos_q   <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < MaxTaps; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        fin_q <= in_word_i.final_in;
        pos_q <= pos_t'(Centre);
        hi_q  <= pos_t'(pend_sat - 1'b1);
        lo_q  <= in_word_i.final_in ? '0 : pos_t'(look);
        if (!emit_any) begin
          pend_q <= pend_sat;
        end else if (in_word_i.final_in) begin
          pend_q <= '0;
        end else begin
          pend_q <= look;
        end
        for (int i = 0; i < MaxTaps; i++) begin
          hist_q[i] <= in_word_i.final_in ? '0 : hist_shift[i];
        end
      end else if (advance) begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  // Scan copy of the history; the frame under work always sits at the centre slot.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= (i < MaxTaps) ? hist_shift[i] : '0;
      end
    end else if (advance) begin
      win_q[0] <= '0;
      for (int i = 1; i < WinLen; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

endmodule

>>> design/vrws_queue.sv
module vrws_queue import vrws_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output q_rd_t q_rd_o
);

  job_t                slot_q [QDepth];
  logic [QPtrBits-1:0] wr_q, rd_q;
  logic [QPtrBits:0]   cnt_q;
  logic                push, pop;

  always_comb begin
    full_o       = cnt_q == (QPtrBits+1)'(QDepth);
    q_rd_o.avail = cnt_q != '0;
    q_rd_o.job   = slot_q[rd_q];
    push         = q_wr_i.push && !full_o;
    pop          = pop_i && q_rd_o.avail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPtrBits'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPtrBits'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= q_wr_i.job;
    end
  end

endmodule

>>> design/vrws_back.sv
module vrws_back import vrws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_rd_t     q_rd_i,
  output logic      pop_o,
  input  tap_cnt_t  taps_i,
  input  weight_t   weights_i [MaxTaps],
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned TopBits = NumBits - QuoBits;

  back_state_e state_q, state_d;

  job_t                         job_q;
  tap_cnt_t                     k_q;
  logic signed [ProdBits-1:0]   prod_q;
  logic signed [AccBits-1:0]    acc_q;
  logic signed [SumBits-1:0]    all_q, used_q;
  logic [NumBits-1:0]           num_q;
  logic [DenBits-1:0]           den_q, rem_q;
  logic [QuoBits-1:0]           quo_q;
  logic [DivCntBits-1:0]        step_q;
  logic                         neg_q;
  sample_t                      res_q;
  logic                         out_valid_q;
  out_word_t                    out_word_q;

  tap_cnt_t                     half;
  pos_t                         tap_j;
  weight_t                      tap_w;
  sample_t                      tap_x;
  logic signed [ProdBits-1:0]   prod_next;
  logic [MagAccBits-1:0]        mag_acc;
  logic [MagSumBits-1:0]        mag_all, mag_used;
  logic [LoBits+MagSumBits-1:0] lo_prod;
  logic [HiBits+MagSumBits-1:0] hi_prod;
  logic [DenBits:0]             r_try;
  logic                         r_ge, round_up, sat, load_out;
  logic [QuoBits:0]             q_rnd;
  logic [TopBits-1:0]           num_top;

  always_comb begin
    half      = taps_i >> 1;
    tap_j     = pos_t'(Reach + half - k_q);
    tap_w     = weights_i[k_q[PosBits-1:0]];
    tap_x     = job_q.win[tap_j];
    prod_next = $signed({1'b0, tap_x}) * tap_w;
    mag_acc   = acc_q[AccBits-1] ? MagAccBits'(-acc_q) : MagAccBits'(acc_q);
    mag_all   = all_q[SumBits-1] ? MagSumBits'(-all_q) : MagSumBits'(all_q);
    mag_used  = used_q[SumBits-1] ? MagSumBits'(-used_q) : MagSumBits'(used_q);
    lo_prod   = mag_acc[LoBits-1:0] * mag_all;
    hi_prod   = mag_acc[MagAccBits-1:LoBits] * mag_all;
    num_top   = num_q[NumBits-1:QuoBits];
    sat       = num_top >= TopBits'(den_q);
    r_try     = {rem_q, num_q[QuoBits-1]};
    r_ge      = r_try >= {1'b0, den_q};
    round_up  = {rem_q, 1'b0} >= {1'b0, den_q};
    q_rnd     = {1'b0, quo_q} + (QuoBits+1)'(round_up);
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (q_rd_i.avail) begin
          pop_o   = 1'b1;
          state_d = BkMac;
        end
      end
      BkMac: begin
        if (k_q == taps_i) begin
          state_d = BkMulLo;
        end
      end
      BkMulLo: begin
        if ((job_q.win[Reach] == '0) || (used_q == '0)) begin
          state_d = BkEmit;
        end else begin
          state_d = BkMulHi;
        end
      end
      BkMulHi: begin
        state_d = BkCheck;
      end
      BkCheck: begin
        state_d = (neg_q || sat) ? BkEmit : BkDiv;
      end
      BkDiv: begin
        if (step_q == DivCntBits'(QuoBits - 1)) begin
          state_d = BkRound;
        end
      end
      BkRound: begin
        state_d = BkEmit;
      end
      BkEmit: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = BkIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_word_q.pitch_out <= res_q;
      out_word_q.final_out <= job_q.last;
    end
    unique case (state_q)
      BkIdle: begin
        job_q  <= q_rd_i.job;
        k_q    <= '0;
        prod_q <= '0;
        acc_q  <= '0;
        all_q  <= '0;
        used_q <= '0;
      end
      BkMac: begin
        acc_q <= acc_q + AccBits'(prod_q);
        if (k_q != taps_i) begin
          k_q   <= k_q + 1'b1;
          all_q <= all_q + SumBits'(tap_w);
          if (job_q.use_tap[tap_j]) begin
            prod_q <= prod_next;
            used_q <= used_q + SumBits'(tap_w);
          end else begin
            prod_q <= '0;
          end
        end
      end
      BkMulLo: begin
        num_q <= NumBits'(lo_prod);
        den_q <= {mag_used, {FracBits{1'b0}}};
        neg_q <= acc_q[AccBits-1] ^ all_q[SumBits-1] ^ used_q[SumBits-1];
        res_q <= '0;
      end
      BkMulHi: begin
        num_q <= num_q + (NumBits'(hi_prod) << LoBits);
      end
      BkCheck: begin
        rem_q  <= DenBits'(num_top);
        quo_q  <= '0;
        step_q <= '0;
        res_q  <= neg_q ? sample_t'(1) : '1;
      end
      BkDiv: begin
        rem_q  <= r_ge ? DenBits'(r_try - {1'b0, den_q}) : DenBits'(r_try);
        quo_q  <= {quo_q[QuoBits-2:0], r_ge};
        num_q  <= num_q << 1;
        step_q <= step_q + 1'b1;
      end
      BkRound: begin
        if (q_rnd == '0) begin
          res_q <= sample_t'(1);
        end else if (q_rnd[QuoBits:SampleBits] != '0) begin
          res_q <= '1;
        end else begin
          res_q <= q_rnd[SampleBits-1:0];
        end
      end
      BkEmit: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import vrws_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned. The longest
  // honest quiet spell is the long output hold plus a settling pause, well under this.
  localparam int unsigned QuietLimit  = 5000;
  // Cycles left after the last expected word, enough for a frame still in the window scan
  // and the arithmetic unit to finish.
  localparam int unsigned SettleCycles = 100;
  // Length of the one long output hold that backs the block up into its input.
  localparam int unsigned LongHold     = 400;

  // Predicts the smoothed pitch words from the accepted frames and checks the block's words
  // against them in order.
  class pitch_scoreboard;
    sample_t           history[MaxTaps];
    logic [MaxTaps-1:0] held_mask;
    int unsigned       held_count;
    logic [2:0]        tap_count_reg;
    weight_t           weights[MaxTaps];
    out_word_t         due_q[$];
    int unsigned       failures;

    function new();
      foreach (history[i]) history[i] = '0;
      foreach (weights[i]) weights[i] = '0;
      weights[0]    = weight_t'(Weight0Reset);
      tap_count_reg = 3'(TapCountReset);
      held_mask     = '0;
      held_count    = 0;
      failures      = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [15:0] data);
      if (idx == RegTapCount) begin
        tap_count_reg = data[2:0];
      end else if (idx >= RegWeightBase && idx < RegWeightBase + MaxTaps) begin
        weights[idx - RegWeightBase] = weight_t'(data);
      end
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction

    // Weighted sum around slot p, renormalized by all weights over the weights used.
    function sample_t smooth_frame(int unsigned p, int unsigned n);
      int unsigned half, ahead, older, newer, j, k;
      longint acc, used, total, num, den, q;
      bit neg;
      if (history[p] == '0) return '0;
      half  = n / 2;
      ahead = n - 1 - half;
      older = 0;
      newer = 0;
      for (j = 1; j <= half; j++) begin
        if (p + j >= MaxTaps || !held_mask[p + j] || history[p + j] == '0) break;
        older = j;
      end
      for (j = 1; j <= ahead; j++) begin
        if (j > p || history[p - j] == '0) break;
        newer = j;
      end
      acc   = 0;
      used  = 0;
      total = 0;
      for (k = 0; k < n; k++) total += longint'(weights[k]);
      for (k = half - older; k <= half + newer; k++) begin
        acc  += longint'(weights[k]) * longint'(history[p + half - k]);
        used += longint'(weights[k]);
      end
      if (used == 0) return '0;
      neg = ((acc < 0) != (total < 0)) != (used < 0);
      num = (acc < 0 ? -acc : acc) * (total < 0 ? -total : total);
      den = (used < 0 ? -used : used) << FracBits;
      // Round half away from zero on the magnitude.
      q = (2 * num + den) / (2 * den);
      if (neg || q == 0) return sample_t'(1);
      if (q > 65535) return '1;
      return sample_t'(q);
    endfunction

    function void note_word(in_word_t w);
      int unsigned n, ahead, i, p;
      out_word_t due;
      n = (tap_count_reg == 0) ? 1 : ((tap_count_reg > MaxTaps) ? MaxTaps : tap_count_reg);
      ahead = n - 1 - n / 2;
      for (i = MaxTaps - 1; i > 0; i--) history[i] = history[i - 1];
      history[0] = w.pitch_in;
      held_mask  = {held_mask[MaxTaps-2:0], 1'b1};
      if (held_count < MaxTaps) held_count++;
      // Everything beyond the lookahead goes out now; on the last frame everything does.
      while (held_count > 0 && (w.final_in || held_count > ahead)) begin
        p = held_count - 1;
        due.pitch_out = smooth_frame(p, n);
        due.final_out = w.final_in && (p == 0);
        due_q.push_back(due);
        held_count--;
      end
      if (w.final_in) begin
        foreach (history[j]) history[j] = '0;
        held_mask  = '0;
        held_count = 0;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t due;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pitch %0d final %0b",
                 $time, got.pitch_out, got.final_out);
        failures++;
        return;
      end
      due = due_q.pop_front();
      if (got.pitch_out !== due.pitch_out) begin
        $display("%0t: pitch_out expected %0d, got %0d", $time, due.pitch_out, got.pitch_out);
        failures++;
      end
      if (got.final_out !== due.final_out) begin
        $display("%0t: final_out expected %0b, got %0b", $time, due.final_out, got.final_out);
        failures++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  in_word_t               in_word_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  out_word_t              out_word_o;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  pitch_scoreboard sb;

  // Shared knobs: how often the sender pauses, whether all idling is off for the closing
  // stretch, and a one-time request for the long output hold.
  int unsigned gap_pct;
  bit          calm;
  bit          hold_req;

  voiced_run_weighted_smoother_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Every word the block hands over is checked at the rising edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(out_word_o);
    end
  end

  // Output ready. Stalls come in random bursts under a stall rate that is redrawn periodically,
  // so that some stretches have none. Once, on request, the receiver holds
  // off for a long spell so that the job queue fills and the input stalls.
  initial begin
    int unsigned stall_left, pct, tick;
    stall_left  = 0;
    pct         = 0;
    tick        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 15;
          default: pct = 40;
        endcase
      end
      tick++;
      if (calm) begin
        stall_left  = 0;
        out_ready_i = 1'b1;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        stall_left  = LongHold - 1;
        out_ready_i = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i = 1'b0;
      end else if ($urandom_range(0, 99) < pct) begin
        stall_left  = $urandom_range(1, 5) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb NOT OK");
    $finish;
  end

  // Offers one frame, after an optional burst of idle cycles, and waits until it is taken.
  task automatic send_word(input logic [15:0] pitch, input logic fin);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i         = 1'b1;
    in_word_i.pitch_in = pitch;
    in_word_i.final_in = fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(in_word_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CfgIdxBits'(idx);
    cfg_data_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Drains the block: every predicted word must arrive, then a frame that produced no word
  // may still be in flight, so a settling pause follows before anything else happens.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Loads a tap count and a fresh set of weights. Mode 0 gives gentle positive smoothing,
  // mode 1 arbitrary weights and mode 2 only the corner values and 1.0.
  task automatic configure(input logic [2:0] taps, input int unsigned mode);
    int unsigned k;
    logic [15:0] w;
    write_reg(RegTapCount, {13'd0, taps});
    for (k = 0; k < MaxTaps; k++) begin
      case (mode)
        0: w = 16'($urandom_range(0, 16384));
        1: w = 16'($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0: w = 16'h8000;
            1: w = 16'h7FFF;
            2: w = 16'h0000;
            default: w = 16'h4000;
          endcase
        end
      endcase
      write_reg(RegWeightBase + k, w);
    end
  endtask

  // Random frames. Most of them form voiced runs that drift around a level, with the odd
  // unvoiced gap or extreme value, ending in a final frame; the rest is noise with random
  // final marks. A phase may stop inside a run, leaving frames held for the next setting.
  task automatic play_frames(input int unsigned count);
    int unsigned left, run_len, k;
    int          level, drift;
    logic [15:0] pitch;
    logic        fin;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 85) begin
        run_len = $urandom_range(1, 12);
        level   = $urandom_range(1, 65535);
        for (k = 0; k < run_len && left > 0; k++) begin
          case ($urandom_range(0, 19))
            0: pitch = 16'h0000;
            1: pitch = 16'hFFFF;
            2: pitch = 16'h0001;
            default: begin
              drift = int'($urandom_range(0, 4096)) - 2048;
              level = level + drift;
              if (level < 1) level = 1;
              if (level > 65535) level = 65535;
              pitch = 16'(level);
            end
          endcase
          fin = (k == run_len - 1);
          send_word(pitch, fin);
          left--;
        end
      end else begin
        pitch = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        fin   = ($urandom_range(0, 3) == 0);
        send_word(pitch, fin);
        left--;
      end
    end
  endtask

  initial begin
    logic [2:0] tap_plan[9];
    int unsigned ph;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    gap_pct     = 20;
    calm        = 1'b0;
    hold_req    = 1'b0;
    tap_plan    = '{3'd7, 3'd0, 3'd5, 3'd2, 3'd3, 3'd6, 3'd4, 3'd1, 3'd7};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers as reset leave them: one tap of 1.0, so frames pass unchanged, including
    // the extremes and an unvoiced frame.
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h1234, 1'b1);
    settle();

    // A tap count of zero acts as one; a single negative weight makes the scaled result
    // negative, so every voiced frame clamps to one.
    write_reg(RegTapCount, 16'd0);
    write_reg(RegWeightBase, 16'h8000);
    send_word(16'd100, 1'b0);
    send_word(16'hFFFF, 1'b1);
    settle();

    // Three taps whose outer pair cancels: the first frame of a run sees only the newer
    // neighbor and so a zero used weight. Large older values push the next frame past the
    // top, and a large newer value drives another one negative, which clamps to one.
    write_reg(RegTapCount, 16'd3);
    write_reg(RegWeightBase + 0, 16'h4000);
    write_reg(RegWeightBase + 1, 16'h4000);
    write_reg(RegWeightBase + 2, 16'hC000);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b1);
    settle();

    // Full window with corner weights. The phase stops with lookahead frames still held,
    // then the tap count drops to two: the held frames must all come out with the next
    // frame. An unvoiced frame and a final frame close the run.
    write_reg(RegTapCount, 16'd7);
    write_reg(RegWeightBase + 0, 16'h7FFF);
    write_reg(RegWeightBase + 1, 16'h1000);
    write_reg(RegWeightBase + 2, 16'h2000);
    write_reg(RegWeightBase + 3, 16'h4000);
    write_reg(RegWeightBase + 4, 16'h2000);
    write_reg(RegWeightBase + 5, 16'h8000);
    write_reg(RegWeightBase + 6, 16'h1000);
    send_word(16'd1000, 1'b0);
    send_word(16'd2000, 1'b0);
    send_word(16'd3000, 1'b0);
    send_word(16'd4000, 1'b0);
    send_word(16'd5000, 1'b0);
    send_word(16'd6000, 1'b0);
    settle();
    write_reg(RegTapCount, 16'd2);
    send_word(16'd7000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'd9000, 1'b1);
    settle();

    // Random phases, each with its own tap count and weights. The second one starts with
    // the long output hold; the last one runs with no idling at all.
    for (ph = 0; ph < 9; ph++) begin
      configure(tap_plan[ph], ph % 3);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      if (ph == 1) hold_req = 1'b1;
      if (ph == 8) calm = 1'b1;
      play_frames(50);
      settle();
    end

    if (sb.failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
